// ===== rtl/iedc_pkg.sv =====
package iedc_pkg;

  // Number of destination table entries, one per cell of the lookup chain.
  localparam int TableEntries = 32;

  // Width of the slot field on the input beat.
  localparam int SlotW = 5;

  // Cell index width: wide enough for the slot field and for every cell.
  localparam int TableIdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int IdxW = (TableIdxW > SlotW) ? TableIdxW : SlotW;

  // Byte counter saturates at the minimum length of an echo request frame.
  localparam int CntW = 6;
  localparam logic [CntW-1:0] FullLen = 6'd42;

  // Byte positions inside the frame (Ethernet header plus a 20-byte IPv4 header).
  localparam logic [CntW-1:0] PosEthHi   = 6'd12;
  localparam logic [CntW-1:0] PosEthLo   = 6'd13;
  localparam logic [CntW-1:0] PosProto   = 6'd23;
  localparam logic [CntW-1:0] PosSrcHi   = 6'd26;
  localparam logic [CntW-1:0] PosSrcLo   = 6'd29;
  localparam logic [CntW-1:0] PosDstHi   = 6'd30;
  localparam logic [CntW-1:0] PosDstLo   = 6'd33;
  localparam logic [CntW-1:0] PosIcmp    = 6'd34;

  localparam logic [15:0] EthIpv4     = 16'h0800;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [7:0]  IcmpEchoReq = 8'd8;

  // Beat kind carried in tuser.
  localparam logic CmdFrame = 1'b0;
  localparam logic CmdWrite = 1'b1;

  // Token that travels down the chain of table cells, one cell per cycle while the chain advances.
  // A write token updates the cell whose index matches; a lookup token
  // collects hits as it passes every cell.
  typedef struct packed {
    logic            valid;
    logic            is_write;
    logic [31:0]     key;       // entry address for writes, destination for lookups
    logic [IdxW-1:0] slot;
    logic            wr_en;     // slot lies inside the table
    logic            wr_valid;
    logic            wr_drop;
    logic            echo;
    logic [31:0]     sip;
    logic            hit;
  } tok_t;

endpackage

// ===== rtl/iedc_parser.sv =====
module iedc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic               cmd_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  logic [4:0]         slot_i,
  input  logic [31:0]        addr_i,
  input  logic               drop_i,
  input  logic               valid_i,
  output iedc_pkg::tok_t     tok_o
);

  logic [iedc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [15:0] eth_q, eth_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [7:0]  icmp_q, icmp_d;
  logic        byte_acc;
  logic        echo;

  assign byte_acc = acc_i && (cmd_i == iedc_pkg::CmdFrame);

  always_comb begin
    eth_d   = eth_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    icmp_d  = icmp_q;
    case (cnt_q) inside
      iedc_pkg::PosEthHi, iedc_pkg::PosEthLo: eth_d = {eth_q[7:0], byte_i};
      iedc_pkg::PosProto: proto_d = byte_i;
      [iedc_pkg::PosSrcHi:iedc_pkg::PosSrcLo]: src_d = {src_q[23:0], byte_i};
      [iedc_pkg::PosDstHi:iedc_pkg::PosDstLo]: dst_d = {dst_q[23:0], byte_i};
      iedc_pkg::PosIcmp: icmp_d = byte_i;
      default: ;
    endcase
    cnt_d = (cnt_q < iedc_pkg::FullLen) ? cnt_q + 1'b1 : cnt_q;
  end

  // The counter saturates at the full length, so equality means "long enough".
  assign echo = (cnt_d == iedc_pkg::FullLen) && (eth_d == iedc_pkg::EthIpv4) &&
                (proto_d == iedc_pkg::ProtoIcmp) && (icmp_d == iedc_pkg::IcmpEchoReq);

  always_comb begin
    tok_o          = '0;
    tok_o.valid    = acc_i && ((cmd_i == iedc_pkg::CmdWrite) || last_i);
    tok_o.is_write = (cmd_i == iedc_pkg::CmdWrite);
    tok_o.slot     = iedc_pkg::IdxW'(slot_i);
    tok_o.wr_en    = (int'(slot_i) < iedc_pkg::TableEntries);
    tok_o.wr_valid = valid_i;
    tok_o.wr_drop  = valid_i && drop_i;
    if (cmd_i == iedc_pkg::CmdWrite) begin
      tok_o.key = addr_i;
    end else begin
      tok_o.echo = echo;
      tok_o.key  = echo ? dst_d : 32'd0;
      tok_o.sip  = echo ? src_d : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      eth_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      icmp_q  <= '0;
    end else if (byte_acc) begin
      if (last_i) begin
        cnt_q   <= '0;
        eth_q   <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        icmp_q  <= '0;
      end else begin
        cnt_q   <= cnt_d;
        eth_q   <= eth_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        icmp_q  <= icmp_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= iedc_pkg::FullLen)
    else $error("byte counter passed its saturation value");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_acc && last_i) |=> (cnt_q == '0 && eth_q == '0 && icmp_q == '0))
    else $error("frame captures not cleared after the last byte");

  a_write_keeps_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && cmd_i == iedc_pkg::CmdWrite) |=> $stable(cnt_q))
    else $error("table write disturbed the frame in progress");
`endif

endmodule

// ===== rtl/iedc_cell.sv =====
module iedc_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [iedc_pkg::IdxW-1:0] idx_i,
  input  iedc_pkg::tok_t            tok_i,
  output iedc_pkg::tok_t            tok_o
);

  iedc_pkg::tok_t tok_q, tok_d;
  logic        ent_valid_q;
  logic        ent_drop_q;
  logic [31:0] ent_key_q;
  logic        hit_here;
  logic        wr_here;

  assign hit_here = tok_i.valid && !tok_i.is_write && tok_i.echo &&
                    ent_valid_q && ent_drop_q && (ent_key_q == tok_i.key);
  assign wr_here  = tok_i.valid && tok_i.is_write && tok_i.wr_en && (tok_i.slot == idx_i);

  always_comb begin
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit | hit_here;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      ent_valid_q <= 1'b0;
      ent_drop_q  <= 1'b0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      if (wr_here) begin
        ent_valid_q <= tok_i.wr_valid;
        ent_drop_q  <= tok_i.wr_drop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && wr_here) begin
      ent_key_q <= tok_i.key;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/icmp_echo_drop_classifier.sv =====
// The verdict beat for a frame is registered at the output after the lookup token has
// walked every table cell, one table cell per cycle while the chain advances.
// Throughput: one input beat per cycle, frame bytes and table writes alike, as long as
// the result side keeps up; a held result stalls the whole chain.
// Reset (rst_ni, asynchronous, active low) empties the table and clears the frame
// captures, the tokens and the output valid flag; stored keys and verdict data are not cleared.
module icmp_echo_drop_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beats.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0 up: frame_byte[7:0], entry_slot[12:8], entry_address[44:13],
  // entry_drop[45], entry_valid[46], zero fill[47].
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // frame_last
  input  logic        s_axis_tuser,   // cmd: 0 frame byte, 1 table write
  // Verdict beats.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0 up: verdict_drop[0], echo_event[1], source_ip[33:2],
  // dest_ip[65:34], zero fill[71:66].
  output logic [71:0] m_axis_tdata
);

  // Token chain: entry 0 comes from the parser, entry k+1 leaves cell k.
  iedc_pkg::tok_t chain [iedc_pkg::TableEntries+1];

  logic        adv;
  logic        acc;
  logic        out_valid_q;
  logic        out_drop_q;
  logic        out_echo_q;
  logic [31:0] out_sip_q;
  logic [31:0] out_dip_q;
  iedc_pkg::tok_t tail;

  // The chain moves as a whole whenever the output register is free or being drained.
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  // The parser captures header fields byte by byte and, on a frame's last byte or on
  // a table write, launches a token into the first cell.
  iedc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .cmd_i  (s_axis_tuser),
    .byte_i (s_axis_tdata[7:0]),
    .last_i (s_axis_tlast),
    .slot_i (s_axis_tdata[12:8]),
    .addr_i (s_axis_tdata[44:13]),
    .drop_i (s_axis_tdata[45]),
    .valid_i(s_axis_tdata[46]),
    .tok_o  (chain[0])
  );

  // Each cell owns one table entry. Writes and lookups travel down the chain in
  // arrival order, so a lookup always sees exactly the writes accepted before it.
  for (genvar k = 0; k < iedc_pkg::TableEntries; k++) begin : g_cell
    iedc_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .idx_i (iedc_pkg::IdxW'(k)),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  assign tail = chain[iedc_pkg::TableEntries];

  // Write tokens leave the chain silently; lookup tokens become verdict beats.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tail.valid && !tail.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_drop_q <= tail.hit;
      out_echo_q <= tail.echo;
      out_sip_q  <= tail.sip;
      out_dip_q  <= tail.key;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_dip_q, out_sip_q, out_echo_q, out_drop_q};

`ifndef NO_ASSERTIONS
  a_drop_needs_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_drop_q) |-> out_echo_q)
    else $error("drop verdict without an echo request");

  a_quiet_addresses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_echo_q) |-> (out_sip_q == 32'd0 && out_dip_q == 32'd0))
    else $error("addresses reported for a frame without an echo event");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && tail.valid && tail.is_write) |=> !out_valid_q)
    else $error("table write produced a verdict beat");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the ICMP echo drop classifier. A queue of input
// beats (frame bytes and table writes) is filled up front; a falling-edge
// driver feeds it to the slave side with random gaps, and a rising-edge
// monitor runs an in-bench model of the classifier on every accepted beat
// and compares each verdict beat against the oldest predicted one.
module tb_top;

  // One input beat before packing onto the stream.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  data;
    logic        last;
    logic [4:0]  slot;
    logic [31:0] addr;
    logic        drop;
    logic        valid;
  } ingress_beat_t;

  // One verdict as the classifier should report it.
  typedef struct packed {
    logic        drop;
    logic        echo;
    logic [31:0] sip;
    logic [31:0] dip;
  } verdict_t;

  // A silent link for this many cycles means the block has hung.
  localparam int StallLimit = 3000;
  // Both sides run without gaps inside this window of cycles.
  localparam int CalmFrom = 1200;
  localparam int CalmTo   = 1700;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  icmp_echo_drop_classifier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ingress_beat_t ingress_q[$];  // beats still to be sent
  verdict_t      verdict_q[$];  // verdicts predicted but not yet seen

  // Model state: the per-frame captures and the destination table.
  logic [iedc_pkg::CntW-1:0] byte_pos;
  logic [15:0]     eth_type;
  logic [7:0]      ip_proto;
  logic [31:0]     src_addr;
  logic [31:0]     dst_addr;
  logic [7:0]      icmp_type;
  logic [31:0]     dest_key   [iedc_pkg::TableEntries];
  logic            dest_valid [iedc_pkg::TableEntries];
  logic            dest_drop  [iedc_pkg::TableEntries];

  int       cycle_no     = 0;
  int       quiet_cycles = 0;
  int       fail_cnt     = 0;
  // A beat is on the bus while the driver has put out more beats than were taken.
  int       sent_cnt     = 0;
  int       taken_cnt    = 0;
  bit       moved;
  verdict_t seen;
  verdict_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gaps on both sides with a 22 percent chance each time, none inside the calm window.
  function automatic bit idle_now();
    if (cycle_no >= CalmFrom && cycle_no < CalmTo) return 1'b0;
    return $urandom_range(0, 99) < 22;
  endfunction

  // Table write beat; the unused frame byte and last flag carry noise.
  function automatic ingress_beat_t make_write(input logic [4:0] slot,
                                               input logic [31:0] addr,
                                               input logic drop, input logic valid);
    ingress_beat_t b;
    b.cmd   = iedc_pkg::CmdWrite;
    b.data  = 8'($urandom);
    b.last  = 1'($urandom);
    b.slot  = slot;
    b.addr  = addr;
    b.drop  = drop;
    b.valid = valid;
    return b;
  endfunction

  // Queue one frame of len bytes with the given header fields at their fixed
  // offsets and random bytes elsewhere. If split_at is a byte index, the beat
  // split_wr goes in just before that byte.
  task automatic queue_frame(input int len, input logic [15:0] eth,
                             input logic [7:0] proto, input logic [31:0] src,
                             input logic [31:0] dst, input logic [7:0] icmp,
                             input int split_at, input ingress_beat_t split_wr);
    ingress_beat_t b;
    for (int i = 0; i < len; i++) begin
      b.cmd   = iedc_pkg::CmdFrame;
      b.data  = 8'($urandom);
      b.last  = (i == len - 1);
      b.slot  = 5'($urandom);
      b.addr  = $urandom;
      b.drop  = 1'($urandom);
      b.valid = 1'($urandom);
      if (i == 12) b.data = eth[15:8];
      else if (i == 13) b.data = eth[7:0];
      else if (i == 23) b.data = proto;
      else if (i >= 26 && i <= 29) b.data = src[8*(29-i) +: 8];
      else if (i >= 30 && i <= 33) b.data = dst[8*(33-i) +: 8];
      else if (i == 34) b.data = icmp;
      if (i == split_at) ingress_q.push_back(split_wr);
      ingress_q.push_back(b);
    end
  endtask

  // Model of the classifier: advance the state by one accepted beat and queue
  // the verdict that a final frame byte produces.
  task automatic classify_beat(input ingress_beat_t b);
    verdict_t v;
    logic     hit;
    if (b.cmd == iedc_pkg::CmdWrite) begin
      // Writes go in order with frame bytes, so they land before any later verdict.
      if (b.slot < iedc_pkg::TableEntries) begin
        dest_key[b.slot]   = b.addr;
        dest_valid[b.slot] = b.valid;
        dest_drop[b.slot]  = b.valid && b.drop;
      end
      return;
    end
    if (byte_pos == iedc_pkg::PosEthHi || byte_pos == iedc_pkg::PosEthLo)
      eth_type = {eth_type[7:0], b.data};
    else if (byte_pos == iedc_pkg::PosProto) ip_proto = b.data;
    else if (byte_pos >= iedc_pkg::PosSrcHi && byte_pos <= iedc_pkg::PosSrcLo)
      src_addr = {src_addr[23:0], b.data};
    else if (byte_pos >= iedc_pkg::PosDstHi && byte_pos <= iedc_pkg::PosDstLo)
      dst_addr = {dst_addr[23:0], b.data};
    else if (byte_pos == iedc_pkg::PosIcmp) icmp_type = b.data;
    if (byte_pos < iedc_pkg::FullLen) byte_pos = byte_pos + 1'b1;
    if (!b.last) return;
    v = '0;
    if (byte_pos >= iedc_pkg::FullLen && eth_type == iedc_pkg::EthIpv4 &&
        ip_proto == iedc_pkg::ProtoIcmp && icmp_type == iedc_pkg::IcmpEchoReq) begin
      hit = 1'b0;
      // Any valid slot holding the destination with its drop flag set drops it.
      for (int i = 0; i < iedc_pkg::TableEntries; i++) begin
        if (dest_valid[i] && dest_drop[i] && dest_key[i] == dst_addr) hit = 1'b1;
      end
      v.drop = hit;
      v.echo = 1'b1;
      v.sip  = src_addr;
      v.dip  = dst_addr;
    end
    verdict_q.push_back(v);
    byte_pos  = '0;
    eth_type  = '0;
    ip_proto  = '0;
    src_addr  = '0;
    dst_addr  = '0;
    icmp_type = '0;
  endtask

  // Driver: a beat stays on the bus until it is taken; a new one may follow
  // right away, so tvalid is simply left high across back-to-back beats.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (sent_cnt == taken_cnt) begin
      if (ingress_q.size() > 0 && !idle_now()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ingress_q[0].valid, ingress_q[0].drop, ingress_q[0].addr,
                          ingress_q[0].slot, ingress_q[0].data};
        s_axis_tlast  <= ingress_q[0].last;
        s_axis_tuser  <= ingress_q[0].cmd;
        sent_cnt++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && !idle_now();
  end

  // Monitor: model the accepted input beat, check the accepted verdict beat,
  // and watch for a link that has gone silent.
  always @(posedge clk_i) begin
    cycle_no++;
    if (rst_ni) begin
      moved = 0;
      if (s_axis_tvalid && s_axis_tready) begin
        classify_beat(ingress_q.pop_front());
        taken_cnt++;
        moved = 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1;
        seen.drop = m_axis_tdata[0];
        seen.echo = m_axis_tdata[1];
        seen.sip  = m_axis_tdata[33:2];
        seen.dip  = m_axis_tdata[65:34];
        if (verdict_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: verdict beat with none pending: expected nothing actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (seen.drop !== want.drop) begin
            fail_cnt++;
            $display("%0t: verdict_drop expected %b actual %b", $time, want.drop, seen.drop);
          end
          if (seen.echo !== want.echo) begin
            fail_cnt++;
            $display("%0t: echo_event expected %b actual %b", $time, want.echo, seen.echo);
          end
          if (seen.sip !== want.sip) begin
            fail_cnt++;
            $display("%0t: source_ip expected %h actual %h", $time, want.sip, seen.sip);
          end
          if (seen.dip !== want.dip) begin
            fail_cnt++;
            $display("%0t: dest_ip expected %h actual %h", $time, want.dip, seen.dip);
          end
          if (m_axis_tdata[71:66] !== 6'd0) begin
            fail_cnt++;
            $display("%0t: tdata fill expected %h actual %h", $time, 6'd0, m_axis_tdata[71:66]);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0]   addr_pool [6];
    ingress_beat_t no_split;
    ingress_beat_t mid_wr;
    int            frames;
    int            kind;
    int            len;
    int            split;
    logic [15:0]   eth;
    logic [7:0]    proto;
    logic [7:0]    icmp;
    logic [31:0]   dst;

    byte_pos  = '0;
    eth_type  = '0;
    ip_proto  = '0;
    src_addr  = '0;
    dst_addr  = '0;
    icmp_type = '0;
    for (int i = 0; i < iedc_pkg::TableEntries; i++) begin
      dest_key[i]   = '0;
      dest_valid[i] = 1'b0;
      dest_drop[i]  = 1'b0;
    end

    // A small set of destinations so that random frames hit the table often.
    addr_pool[0] = $urandom;
    addr_pool[1] = $urandom;
    addr_pool[2] = $urandom;
    addr_pool[3] = $urandom;
    addr_pool[4] = 32'h0000_0000;
    addr_pool[5] = 32'hFFFF_FFFF;
    no_split = make_write('0, '0, 1'b0, 1'b0);

    // Directed part. Install entries at both ends of the table, one without a
    // drop flag, and one write that leaves its slot invalid.
    ingress_q.push_back(make_write(5'd0,  addr_pool[0], 1'b1, 1'b1));
    ingress_q.push_back(make_write(5'd31, 32'hFFFF_FFFF, 1'b1, 1'b1));
    ingress_q.push_back(make_write(5'd5,  addr_pool[1], 1'b0, 1'b1));
    ingress_q.push_back(make_write(5'd17, 32'h0000_0000, 1'b1, 1'b0));
    // Echo requests: hit with drop, hit in the last slot, miss on an invalid
    // slot, and hit on a slot without its drop flag (longer frame, saturating count).
    queue_frame(42, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, 32'hFFFF_FFFF, addr_pool[0],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    queue_frame(42, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, 32'h0000_0000, 32'hFFFF_FFFF,
                iedc_pkg::IcmpEchoReq, -1, no_split);
    queue_frame(42, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, 32'h0000_0000,
                iedc_pkg::IcmpEchoReq, -1, no_split);
    queue_frame(60, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[1],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    // Duplicate key: a second slot with the same destination and drop set.
    ingress_q.push_back(make_write(5'd10, addr_pool[1], 1'b1, 1'b1));
    queue_frame(42, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[1],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    // Removal of that duplicate, with drop still asserted on the write.
    ingress_q.push_back(make_write(5'd10, addr_pool[1], 1'b1, 1'b0));
    queue_frame(42, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[1],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    // A write in the middle of a frame removes the entry the frame would hit.
    queue_frame(42, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[0],
                iedc_pkg::IcmpEchoReq, 20, make_write(5'd0, addr_pool[0], 1'b1, 1'b0));
    // Short frames: a single byte, one short of the addresses, exactly up to
    // the ICMP type, and one byte short of a full echo request.
    queue_frame(1,  iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[5],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    queue_frame(33, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[5],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    queue_frame(34, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[5],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    queue_frame(41, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[5],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    // Not IPv4, not ICMP, an echo reply, and a long echo request that drops.
    queue_frame(42, 16'h86DD, iedc_pkg::ProtoIcmp, $urandom, addr_pool[5],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    queue_frame(42, iedc_pkg::EthIpv4, 8'd6, $urandom, addr_pool[5],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    queue_frame(42, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[5], 8'd0,
                -1, no_split);
    queue_frame(63, iedc_pkg::EthIpv4, iedc_pkg::ProtoIcmp, $urandom, addr_pool[5],
                iedc_pkg::IcmpEchoReq, -1, no_split);
    frames = 15;

    // Random part: mostly well-formed echo requests aimed at the address pool,
    // with table churn, short frames, damaged headers and plain noise mixed in.
    while (ingress_q.size() < 1950 || frames < 60) begin
      if ($urandom_range(0, 99) < 12) begin
        ingress_q.push_back(make_write(5'($urandom),
                                       ($urandom_range(0, 4) != 0) ?
                                       addr_pool[$urandom_range(0, 5)] : $urandom,
                                       1'($urandom), $urandom_range(0, 4) != 0));
      end else begin
        kind  = $urandom_range(0, 99);
        eth   = iedc_pkg::EthIpv4;
        proto = iedc_pkg::ProtoIcmp;
        icmp  = iedc_pkg::IcmpEchoReq;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(57, 63) : $urandom_range(42, 48);
        dst   = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 5)] : $urandom;
        if (kind >= 70 && kind < 80) begin
          len = $urandom_range(1, 41);
        end else if (kind >= 80 && kind < 90) begin
          case ($urandom_range(0, 2))
            0: eth = 16'($urandom);
            1: proto = 8'($urandom);
            default: icmp = 8'($urandom);
          endcase
        end else if (kind >= 90) begin
          len   = $urandom_range(1, 63);
          eth   = 16'($urandom);
          proto = 8'($urandom);
          icmp  = 8'($urandom);
        end
        split = -1;
        mid_wr = no_split;
        if ($urandom_range(0, 9) == 0) begin
          split  = $urandom_range(0, len - 1);
          mid_wr = make_write(5'($urandom), addr_pool[$urandom_range(0, 5)],
                              1'($urandom), 1'($urandom));
        end
        queue_frame(len, eth, proto, $urandom, dst, icmp, split, mid_wr);
        frames++;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (ingress_q.size() == 0 && verdict_q.size() == 0);
    // Let the lookup chain drain so any stray verdict still shows up.
    repeat (iedc_pkg::TableEntries + 8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
